### rtl/prtt_pkg.sv
// Package for the periodic report timer table.
// Holds field widths, command codes and the table entry layout.
// No dependencies.
package prtt_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int ID_W   = 8;
  localparam int TIME_W = 32;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEACT  = 2'd2;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd10000;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

### rtl/periodic_report_timer_table.sv
// Periodic report timer table: top level with the entry memory and scan engine.
// Depends on prtt_pkg.
//
// The block holds up to ENTRIES subscriptions in one single-port-write,
// single-port-read synchronous memory (registered read data). Every
// command (tick, activate, deactivate) walks the occupied entries in table
// order, one entry per cycle while the scan does not stall, re-writing kept
// entries to a compacting write pointer, so removals close gaps as they go.
// An accepted item is finished before the next one is taken: the idle
// state accepts it and issues the first read, the scan state handles each
// entry as a read-modify-write through the memory port, and a closing
// state ends the scan. Unused command code three is accepted and ignored.
// A tick may take longer if the result channel stalls: the scan holds while
// a due event cannot be handed to the output register. The configuration port
// is always ready; write lifetime_ticks only while the block is idle.
module periodic_report_timer_table #(
  parameter int ENTRIES = prtt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] resource_id, [39:8] period_ticks
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] event_id
  output logic        out_tlast,
  // configuration: lifetime_ticks
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // entry memory
  prtt_pkg::entry_t mem [ENTRIES];
  prtt_pkg::entry_t rdata_r;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  prtt_pkg::entry_t mem_wd;
  logic             mem_re;
  logic [IW-1:0]    mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // control state
  logic [1:0]                    state_r,    state_nxt;
  logic [prtt_pkg::TIME_W-1:0]   time_r,     time_nxt;
  logic [prtt_pkg::TIME_W-1:0]   life_r,     life_nxt;
  logic [CW-1:0]                 count_r,    count_nxt;
  logic [CW-1:0]                 left_r,     left_nxt;
  logic [CW-1:0]                 wr_r,       wr_nxt;
  logic [IW-1:0]                 rd_r,       rd_nxt;
  logic                          found_r,    found_nxt;
  logic [prtt_pkg::CMD_W-1:0]    cmd_r,      cmd_nxt;
  logic [prtt_pkg::ID_W-1:0]     id_r,       id_nxt;
  logic [prtt_pkg::TIME_W-1:0]   period_r,   period_nxt;
  logic                          pend_v_r,   pend_v_nxt;
  logic [prtt_pkg::ID_W-1:0]     pend_id_r,  pend_id_nxt;
  logic                          out_v_r,    out_v_nxt;
  logic [prtt_pkg::ID_W-1:0]     out_id_r,   out_id_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          out_free;
  logic                          push;
  logic [prtt_pkg::ID_W-1:0]     push_id;
  logic                          push_last;
  logic                          emit;
  logic                          expire;
  logic                          match;
  logic                          drop;
  logic                          stall;
  prtt_pkg::entry_t              upd;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_id_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_v_r || out_tready;

  // per-entry decisions on the registered read data
  always_comb begin
    emit   = (cmd_r == prtt_pkg::CMD_TICK) && (rdata_r.due <= time_r);
    expire = (cmd_r == prtt_pkg::CMD_TICK) && (rdata_r.expiry <= time_r);
    match  = (rdata_r.id == id_r);
    drop   = expire || ((cmd_r == prtt_pkg::CMD_DEACT) && match);
    stall  = emit && pend_v_r && !out_free;
    upd    = rdata_r;
    if (emit) begin
      upd.due = time_r + rdata_r.period;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    time_nxt    = time_r;
    life_nxt    = life_r;
    count_nxt   = count_r;
    left_nxt    = left_r;
    wr_nxt      = wr_r;
    rd_nxt      = rd_r;
    found_nxt   = found_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    period_nxt  = period_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    mem_we      = 1'b0;
    mem_wa      = wr_r[IW-1:0];
    mem_wd      = upd;
    mem_re      = 1'b0;
    mem_ra      = rd_r;
    push        = 1'b0;
    push_id     = pend_id_r;
    push_last   = 1'b0;

    if (cfg_valid) begin
      life_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_tuser;
          id_nxt     = in_tdata[7:0];
          period_nxt = in_tdata[39:8];
          wr_nxt     = '0;
          rd_nxt     = IW'(1);
          found_nxt  = 1'b0;
          left_nxt   = count_r;
          if (in_tuser == prtt_pkg::CMD_TICK || in_tuser == prtt_pkg::CMD_ACT ||
              in_tuser == prtt_pkg::CMD_DEACT) begin
            if (in_tuser == prtt_pkg::CMD_TICK) begin
              time_nxt = time_r + 32'd1;
            end
            if (count_r == '0) begin
              state_nxt = ST_FIN;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = '0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          // write back kept entries at the compacting pointer
          if (!drop) begin
            mem_we = 1'b1;
            wr_nxt = wr_r + CW'(1);
          end
          if (emit) begin
            if (pend_v_r) begin
              push = 1'b1;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = rdata_r.id;
          end
          if ((cmd_r == prtt_pkg::CMD_ACT) && match) begin
            found_nxt = 1'b1;
          end
          left_nxt = left_r - CW'(1);
          if (left_r == CW'(1)) begin
            state_nxt = ST_FIN;
          end else begin
            mem_re = 1'b1;
            rd_nxt = rd_r + IW'(1);
          end
        end
      end
      ST_FIN: begin
        count_nxt = wr_r;
        if ((cmd_r == prtt_pkg::CMD_ACT) && !found_r && (wr_r < FULL)) begin
          mem_we        = 1'b1;
          mem_wd.id     = id_r;
          mem_wd.period = period_r;
          mem_wd.due    = time_r + period_r;
          mem_wd.expiry = time_r + life_r;
          count_nxt     = wr_r + CW'(1);
        end
        // flush the held event as the final beat of the tick
        if (pend_v_r) begin
          if (out_free) begin
            push       = 1'b1;
            push_last  = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_v_nxt    = 1'b1;
      out_id_nxt   = push_id;
      out_last_nxt = push_last;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      time_r   <= '0;
      life_r   <= prtt_pkg::LIFETIME_RST;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      life_r   <= life_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r     <= left_nxt;
    wr_r       <= wr_nxt;
    rd_r       <= rd_nxt;
    found_r    <= found_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    period_r   <= period_nxt;
    pend_id_r  <= pend_id_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count above table depth");

  a_pend_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (cmd_r == prtt_pkg::CMD_TICK))
    else $error("event held outside a tick scan");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held event lost on return to idle");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (left_r != '0) && (wr_r + left_r <= count_r))
    else $error("scan pointers out of step");
`endif

endmodule
